>>> design/ssi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants for the sorted set insertion block.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int VALUE_W       = 32;
  localparam int ENTRY_COUNT_W = 7;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [ENTRY_COUNT_W-1:0]  entry_count_t;

  // what a cell hands to the next cell up the row
  typedef struct packed {
    value_t data;  // stored entry
    logic   occ;   // entry holds a live value
    logic   gt;    // live entry greater than the broadcast value
  } link_t;

  // lower boundary of the row: behaves as a live entry below any value
  localparam link_t LINK_BOUNDARY = '{data: '0, occ: 1'b1, gt: 1'b0};

endpackage

>>> design/ssi_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_in_if
// Input channel: one value per transaction.
// ----------------------------------------------------------------------------
interface ssi_in_if;
  import ssi_pkg::*;

  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);

endinterface

>>> design/ssi_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_out_if
// Result channel: insert status and entry count per transaction.
// ----------------------------------------------------------------------------
interface ssi_out_if;
  import ssi_pkg::*;

  logic         valid;
  logic         ready;
  logic         inserted;
  logic         overflow;
  entry_count_t entry_count;

  modport source (output valid, output inserted, output overflow, output entry_count,
                  input ready);
  modport sink   (input valid, input inserted, input overflow, input entry_count,
                  output ready);

endinterface

>>> design/ssi_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_cell
// One entry of the sorted row: compares its entry with the broadcast value,
// and on an insert either keeps it, takes the new value or takes the entry
// of the cell below.
// ----------------------------------------------------------------------------
module ssi_cell (
  input  logic           clk,
  input  logic           occ,
  input  logic           insert,
  input  ssi_pkg::value_t value,
  input  ssi_pkg::link_t  link_in,
  output ssi_pkg::link_t  link_out,
  output logic           eq
);
  import ssi_pkg::*;

  value_t data;
  value_t data_next;
  logic   gt;
  logic   below_live;

  assign gt         = occ && (data > value);
  assign eq         = occ && (data == value);
  // cell below holds a live value not greater than the new one
  assign below_live = link_in.occ && !link_in.gt;

  always_comb begin
    data_next = data;
    if (insert) begin
      if (link_in.gt) begin
        data_next = link_in.data;
      end else if (below_live && (gt || !occ)) begin
        data_next = value;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign link_out = '{data: data, occ: occ, gt: gt};

endmodule

>>> design/sorted_set_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_insert
// Sorted set of signed values held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// result: held in the output register from the cycle after the transaction
// throughput: one value per cycle unless out_ch stalls, set by the broadcast
//   compare across the cell row and the count update the next value depends on
// reset: clears the entry count and the output valid; cell contents stay as
//   they are and only entries below the count are ever looked at
module sorted_set_insert #(
  parameter int unsigned CAPACITY = 64
) (
  input logic      clk,
  input logic      rst,
  ssi_in_if.sink   in_ch,
  ssi_out_if.source out_ch
);
  import ssi_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] eq_vec;
  link_t               links [CAPACITY];

  logic accept;
  logic dup;
  logic full;
  logic do_insert;

  logic         out_valid;
  logic         out_inserted;
  logic         out_overflow;
  entry_count_t out_entry_count;

  assign in_ch.ready = !rst && (!out_valid || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    link_t link_in;

    assign occ[i] = IDX < count;

    if (i == 0) begin : g_first
      assign link_in = LINK_BOUNDARY;
    end else begin : g_rest
      assign link_in = links[i-1];
    end

    ssi_cell u_cell (
      .clk      (clk),
      .occ      (occ[i]),
      .insert   (do_insert),
      .value    (in_ch.value),
      .link_in  (link_in),
      .link_out (links[i]),
      .eq       (eq_vec[i])
    );
  end

  assign dup       = |eq_vec;
  assign full      = count == FULL_COUNT;
  assign do_insert = accept && !dup && !full;

  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_inserted    <= do_insert;
      out_overflow    <= !dup && full;
      out_entry_count <= ENTRY_COUNT_W'(count_next);
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.inserted    = out_inserted;
  assign out_ch.overflow    = out_overflow;
  assign out_ch.entry_count = out_entry_count;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above capacity");

  a_insert_count : assert property (@(posedge clk) disable iff (rst)
    do_insert |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not advance the entry count");

  a_full_drop : assert property (@(posedge clk) disable iff (rst)
    (accept && full && !dup) |=> out_ch.valid && out_ch.overflow && !out_ch.inserted)
    else $error("new value on a full store not flagged as dropped");

  a_flags_excl : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.inserted && out_ch.overflow))
    else $error("result both inserted and dropped");

  a_hold_stall : assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(count))
    else $error("state moved while a result was stalled");

endmodule
